/* hdl/kpc_pkg.sv */
`timescale 1ns / 1ps

package kpc_pkg;

    // default counter width and the auto-repeat gap above the long threshold
    localparam int COUNT_WIDTH_DEFAULT = 8;
    localparam int REPEAT_GAP          = 15;

    // configuration register widths and reset values
    localparam int          CFG_WIDTH        = 8;
    localparam int          CFG_INDEX_WIDTH  = 2;
    localparam logic [7:0]  LONG_PRESS_RESET = 8'd50;
    localparam logic [7:0]  HOLD_LIMIT_RESET = 8'd255;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_LIMIT = 2'd1;

    // event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SHORT  = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_REPEAT = 2'd3;

    // one scan tick: active-low key levels
    typedef struct packed {
        logic mode_key_level;
        logic up_key_level;
        logic down_key_level;
    } key_levels_t;

    // one result word: event pulses
    typedef struct packed {
        logic [1:0] combo_event;
        logic [1:0] mode_event;
        logic [1:0] up_event;
        logic [1:0] down_event;
    } key_events_t;

endpackage

/* hdl/key_press_classifier_unit.sv */
`timescale 1ns / 1ps

// an accepted tick word's result word is registered and valid in the next cycle
// throughput: one tick word per cycle; the only hold-off is a stalled result register
// each accepted tick updates the four hold counters and the result register in a single pass
// reset: hold counters clear, result register empties, long press 50, hold limit 255
// a result word waiting on a stall blocks the next tick only while it is not taken
module key_press_classifier_unit
    import kpc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    input  logic                       key_valid,
    output logic                       key_stall,
    input  key_levels_t                key_word,
    output logic                       result_valid,
    input  logic                       result_stall,
    output key_events_t                result_word
);

    // compare width holds counters, config values and long press plus the repeat gap
    localparam int CMP_W = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;
    localparam logic [CMP_W-1:0] COUNT_TOP = CMP_W'((1 << COUNT_WIDTH) - 1);
    localparam logic [CMP_W-1:0] GAP_X     = CMP_W'(REPEAT_GAP);

    logic [CFG_WIDTH-1:0]   long_press_reg;
    logic [CFG_WIDTH-1:0]   hold_limit_reg;
    logic [COUNT_WIDTH-1:0] combo_hold_count_reg, combo_hold_count_next;
    logic [COUNT_WIDTH-1:0] mode_hold_count_reg,  mode_hold_count_next;
    logic [COUNT_WIDTH-1:0] up_hold_count_reg,    up_hold_count_next;
    logic [COUNT_WIDTH-1:0] down_hold_count_reg,  down_hold_count_next;
    logic                   result_valid_reg;
    key_events_t            result_word_reg, result_word_next;

    logic             key_accept;
    logic [CMP_W-1:0] lp_x;
    logic [CMP_W-1:0] cap_x;

    // ordinary key without repeat: returns event, updates count
    function automatic logic [1:0] plain_key(
        input  logic                   pressed,
        input  logic [COUNT_WIDTH-1:0] cnt,
        input  logic [CMP_W-1:0]       lp,
        input  logic [CMP_W-1:0]       cap,
        output logic [COUNT_WIDTH-1:0] cnt_next
    );
        logic [CMP_W-1:0] cx;
        logic [1:0]       ev;
        cx       = CMP_W'(cnt);
        ev       = EV_NONE;
        cnt_next = cnt;
        if (pressed)
        begin
            if (cx < cap)
            begin
                cnt_next = cnt + COUNT_WIDTH'(1);
                if ((cx + CMP_W'(1)) == lp)
                begin
                    ev = EV_LONG;
                end
            end
        end
        else
        begin
            if ((cx != '0) && (cx < lp))
            begin
                ev = EV_SHORT;
            end
            cnt_next = '0;
        end
        return ev;
    endfunction

    // handshake
    assign key_accept   = key_valid && !key_stall;
    assign key_stall    = result_valid_reg && result_stall;
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // effective cap and threshold
    assign lp_x  = CMP_W'(long_press_reg);
    assign cap_x = (CMP_W'(hold_limit_reg) < COUNT_TOP) ? CMP_W'(hold_limit_reg) : COUNT_TOP;

    // per-tick counter and event update
    always_comb
    begin
        logic             mode_p;
        logic             up_p;
        logic             down_p;
        logic             singles;
        logic [CMP_W-1:0] combo_x;
        logic [CMP_W-1:0] mode_x;
        logic [CMP_W-1:0] mode_inc_x;

        mode_p  = !key_word.mode_key_level;
        up_p    = !key_word.up_key_level;
        down_p  = !key_word.down_key_level;
        singles = 1'b1;
        combo_x = CMP_W'(combo_hold_count_reg);
        mode_x  = CMP_W'(mode_hold_count_reg);
        mode_inc_x = mode_x + CMP_W'(1);

        result_word_next       = '0;
        combo_hold_count_next  = combo_hold_count_reg;
        mode_hold_count_next   = mode_hold_count_reg;
        up_hold_count_next     = up_hold_count_reg;
        down_hold_count_next   = down_hold_count_reg;

        // combo of mode and up
        if (mode_p && up_p)
        begin
            if (combo_x < cap_x)
            begin
                combo_hold_count_next = combo_hold_count_reg + COUNT_WIDTH'(1);
                if ((combo_x + CMP_W'(1)) == lp_x)
                begin
                    result_word_next.combo_event = EV_LONG;
                end
            end
            singles = 1'b0;
        end
        else
        begin
            if ((combo_x != '0) && (combo_x < lp_x))
            begin
                result_word_next.combo_event = EV_SHORT;
                singles = 1'b0;
            end
            combo_hold_count_next = '0;
        end

        // single keys
        if (singles)
        begin
            if (mode_p)
            begin
                if (mode_x < cap_x)
                begin
                    mode_hold_count_next = mode_hold_count_reg + COUNT_WIDTH'(1);
                    if (mode_inc_x == lp_x)
                    begin
                        result_word_next.mode_event = EV_LONG;
                    end
                    else if (mode_inc_x > (lp_x + GAP_X))
                    begin
                        result_word_next.mode_event = EV_REPEAT;
                        mode_hold_count_next = COUNT_WIDTH'(long_press_reg);
                    end
                end
            end
            else
            begin
                if ((mode_x != '0) && (mode_x < lp_x))
                begin
                    result_word_next.mode_event = EV_SHORT;
                end
                mode_hold_count_next = '0;
            end
            result_word_next.up_event = plain_key(up_p, up_hold_count_reg, lp_x, cap_x,
                                                  up_hold_count_next);
            result_word_next.down_event = plain_key(down_p, down_hold_count_reg, lp_x, cap_x,
                                                    down_hold_count_next);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RESET;
            hold_limit_reg <= HOLD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_HOLD_LIMIT: hold_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combo_hold_count_reg <= '0;
            mode_hold_count_reg  <= '0;
            up_hold_count_reg    <= '0;
            down_hold_count_reg  <= '0;
        end
        else if (key_accept)
        begin
            combo_hold_count_reg <= combo_hold_count_next;
            mode_hold_count_reg  <= mode_hold_count_next;
            up_hold_count_reg    <= up_hold_count_next;
            down_hold_count_reg  <= down_hold_count_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (key_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (key_accept)
        begin
            result_word_reg <= result_word_next;
        end
    end

    // an accepted tick always leaves a result word behind
    assert property (@(posedge clk) disable iff (!rst_n)
        key_accept |=> result_valid)
        else $error("accepted tick word produced no result word");

    // combo held freezes the single-key counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (key_accept && !key_word.mode_key_level && !key_word.up_key_level)
        |=> ($stable(mode_hold_count_reg) && $stable(up_hold_count_reg)
             && $stable(down_hold_count_reg)))
        else $error("single-key counter moved while combo held");

    // combo held gives no single-key events
    assert property (@(posedge clk) disable iff (!rst_n)
        (key_accept && !key_word.mode_key_level && !key_word.up_key_level)
        |=> (result_word_reg.mode_event == EV_NONE && result_word_reg.up_event == EV_NONE
             && result_word_reg.down_event == EV_NONE))
        else $error("single-key event while combo held");

    // a repeat reloads the mode counter with the long threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        (key_accept && result_word_next.mode_event == EV_REPEAT)
        |=> (mode_hold_count_reg == COUNT_WIDTH'(long_press_reg)))
        else $error("mode counter not reloaded on repeat");

    // a long up event lands exactly on the threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        (key_accept && result_word_next.up_event == EV_LONG)
        |=> (CMP_W'(up_hold_count_reg) == CMP_W'(long_press_reg)))
        else $error("up long event off threshold");

endmodule

/* tb/key_press_classifier_unit_tb.sv */
`timescale 1ns / 1ps

module key_press_classifier_unit_tb;
    import kpc_pkg::*;

    // spare register indexes, writes there must be ignored
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

    // hold counter slots
    localparam int KEY_COMBO = 0;
    localparam int KEY_MODE  = 1;
    localparam int KEY_UP    = 2;
    localparam int KEY_DOWN  = 3;

    localparam key_levels_t KEYS_RELEASED = 3'b111;

    localparam int PHASES       = 10;
    localparam int PHASE_TICKS  = 120;
    localparam int RANDOM_PHASE = 8;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES = 3;

    // threshold and hold limit per phase (the random phase draws its own), extremes included
    localparam int PHASE_LONG  [PHASES] = '{4, 0, 1, 255, 6, 9, 3, 0, 0, 50};
    localparam int PHASE_LIMIT [PHASES] = '{255, 255, 1, 255, 20, 5, 18, 0, 0, 255};

    typedef enum logic { ROW_TICK, ROW_WRITE } row_kind_e;

    typedef struct packed {
        row_kind_e                  kind;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [CFG_WIDTH-1:0]       data;
        key_levels_t                levels;
        logic                       typed;
        key_events_t                want;
    } script_row_t;

    localparam key_events_t NO_EVENTS = '{EV_NONE, EV_NONE, EV_NONE, EV_NONE};

    // directed script: reset defaults, spare indexes, short/long, combo rules, limit extremes
    localparam int SCRIPT_ROWS = 28;
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b1, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b000, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b1,
            '{EV_SHORT, EV_NONE, EV_NONE, EV_NONE}},
        '{ROW_WRITE, REG_LONG_PRESS, 8'd3,   3'b111, 1'b0, NO_EVENTS},
        '{ROW_WRITE, REG_SPARE_2,    8'hFF,  3'b111, 1'b0, NO_EVENTS},
        '{ROW_WRITE, REG_SPARE_3,    8'hA5,  3'b111, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b011, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b1,
            '{EV_NONE, EV_SHORT, EV_NONE, EV_NONE}},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b101, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b101, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b101, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b110, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b110, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b1,
            '{EV_NONE, EV_NONE, EV_NONE, EV_SHORT}},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b001, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b001, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b001, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b011, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b0, NO_EVENTS},
        '{ROW_WRITE, REG_HOLD_LIMIT, 8'd0,   3'b111, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b000, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b1, NO_EVENTS},
        '{ROW_WRITE, REG_HOLD_LIMIT, 8'd2,   3'b111, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b110, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b110, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b110, 1'b0, NO_EVENTS},
        '{ROW_TICK,  REG_LONG_PRESS, 8'd0,   3'b111, 1'b0, NO_EVENTS}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_LONG_PRESS;
    logic [CFG_WIDTH-1:0]       cfg_data = '0;
    logic                       key_valid = 1'b0;
    logic                       key_stall;
    key_levels_t                key_word = KEYS_RELEASED;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    key_events_t                result_word;

    // predictor state and register copies
    int          long_ticks;
    int          limit_ticks;
    int          hold_cnt [4];
    key_events_t pending_events [$];
    key_events_t oldest_events;

    int fail_count = 0;
    int ticks_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_req = 0;
    int hold_off_served = 0;
    int hold_off_left = 0;

    key_press_classifier_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_word     (key_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // counters stop at the hold limit or at the counter's full scale
    function automatic int hold_cap();
        int top;
        top = (1 << COUNT_WIDTH_DEFAULT) - 1;
        return (limit_ticks < top) ? limit_ticks : top;
    endfunction

    function automatic logic [1:0] plain_key_event(input bit pressed, input int k);
        logic [1:0] ev;
        ev = EV_NONE;
        if (pressed)
        begin
            if (hold_cnt[k] < hold_cap())
            begin
                hold_cnt[k]++;
                if (hold_cnt[k] == long_ticks)
                    ev = EV_LONG;
            end
        end
        else
        begin
            if (hold_cnt[k] > 0 && hold_cnt[k] < long_ticks)
                ev = EV_SHORT;
            hold_cnt[k] = 0;
        end
        return ev;
    endfunction

    // one scan tick through the predictor
    function automatic key_events_t predict_events(input key_levels_t lv);
        key_events_t ev;
        bit          mode_p;
        bit          up_p;
        bit          down_p;
        bit          singles;
        ev      = NO_EVENTS;
        mode_p  = !lv.mode_key_level;
        up_p    = !lv.up_key_level;
        down_p  = !lv.down_key_level;
        singles = 1'b1;

        // mode+up combo freezes the single keys
        if (mode_p && up_p)
        begin
            if (hold_cnt[KEY_COMBO] < hold_cap())
            begin
                hold_cnt[KEY_COMBO]++;
                if (hold_cnt[KEY_COMBO] == long_ticks)
                    ev.combo_event = EV_LONG;
            end
            singles = 1'b0;
        end
        else
        begin
            if (hold_cnt[KEY_COMBO] > 0 && hold_cnt[KEY_COMBO] < long_ticks)
            begin
                ev.combo_event = EV_SHORT;
                singles = 1'b0;
            end
            hold_cnt[KEY_COMBO] = 0;
        end

        if (singles)
        begin
            // mode key with auto-repeat
            if (mode_p)
            begin
                if (hold_cnt[KEY_MODE] < hold_cap())
                begin
                    hold_cnt[KEY_MODE]++;
                    if (hold_cnt[KEY_MODE] == long_ticks)
                        ev.mode_event = EV_LONG;
                    else if (hold_cnt[KEY_MODE] > long_ticks + REPEAT_GAP)
                    begin
                        ev.mode_event = EV_REPEAT;
                        hold_cnt[KEY_MODE] = long_ticks;
                    end
                end
            end
            else
            begin
                if (hold_cnt[KEY_MODE] > 0 && hold_cnt[KEY_MODE] < long_ticks)
                    ev.mode_event = EV_SHORT;
                hold_cnt[KEY_MODE] = 0;
            end
            ev.up_event   = plain_key_event(up_p, KEY_UP);
            ev.down_event = plain_key_event(down_p, KEY_DOWN);
        end
        return ev;
    endfunction

    // wait until every expected word is back and the block has settled
    task automatic wait_drained();
        key_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write while idle, predictor copy updated alongside
    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_WIDTH-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_LONG_PRESS)
            long_ticks = int'(value);
        else if (idx == REG_HOLD_LIMIT)
            limit_ticks = int'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one tick word, record its expected events once taken
    task automatic send_tick(input key_levels_t lv, input bit typed = 1'b0,
                             input key_events_t want = '0);
        key_events_t ev;
        while ($urandom_range(99) < send_idle_pct)
        begin
            key_valid <= 1'b0;
            @(negedge clk);
        end
        key_valid <= 1'b1;
        key_word  <= lv;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        ev = predict_events(lv);
        pending_events.push_back(typed ? want : ev);
        ticks_sent++;
        @(negedge clk);
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_off_req != hold_off_served)
        begin
            hold_off_served = hold_off_req;
            hold_off_left   = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("result word with nothing expected: %h", result_word);
                fail_count++;
            end
            else
            begin
                oldest_events = pending_events.pop_front();
                if (result_word.combo_event !== oldest_events.combo_event)
                begin
                    $error("combo_event: expected %0d, got %0d",
                           oldest_events.combo_event, result_word.combo_event);
                    fail_count++;
                end
                if (result_word.mode_event !== oldest_events.mode_event)
                begin
                    $error("mode_event: expected %0d, got %0d",
                           oldest_events.mode_event, result_word.mode_event);
                    fail_count++;
                end
                if (result_word.up_event !== oldest_events.up_event)
                begin
                    $error("up_event: expected %0d, got %0d",
                           oldest_events.up_event, result_word.up_event);
                    fail_count++;
                end
                if (result_word.down_event !== oldest_events.down_event)
                begin
                    $error("down_event: expected %0d, got %0d",
                           oldest_events.down_event, result_word.down_event);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int          r;
        int          p;
        int          lp;
        int          dur;
        int          phase_start;
        key_levels_t lv;

        long_ticks  = LONG_PRESS_RESET;
        limit_ticks = HOLD_LIMIT_RESET;
        foreach (hold_cnt[k])
            hold_cnt[k] = 0;

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed script
        for (r = 0; r < SCRIPT_ROWS; r++)
        begin
            if (SCRIPT[r].kind == ROW_WRITE)
                write_register(SCRIPT[r].index, SCRIPT[r].data);
            else
                send_tick(SCRIPT[r].levels, SCRIPT[r].typed, SCRIPT[r].want);
        end

        // random phases: press episodes with random content, plus noise
        for (p = 0; p < PHASES; p++)
        begin
            if (p == RANDOM_PHASE)
            begin
                write_register(REG_LONG_PRESS, CFG_WIDTH'($urandom_range(1, 30)));
                write_register(REG_HOLD_LIMIT, CFG_WIDTH'($urandom_range(10, 255)));
            end
            else
            begin
                write_register(REG_LONG_PRESS, CFG_WIDTH'(PHASE_LONG[p]));
                write_register(REG_HOLD_LIMIT, CFG_WIDTH'(PHASE_LIMIT[p]));
            end

            // idling pattern for this phase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (p == 1 || p == 6)
                hold_off_req++;

            lp = long_ticks;
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS)
            begin
                if ($urandom_range(99) < 15)
                begin
                    repeat ($urandom_range(1, 8))
                        send_tick(key_levels_t'(3'($urandom_range(7))));
                end
                else
                begin
                    lv = key_levels_t'(~3'($urandom_range(1, 7)));
                    r = $urandom_range(99);
                    if (r < 40)
                        dur = $urandom_range(1, lp + 2);
                    else if (r < 80)
                        dur = $urandom_range(lp, lp + 40);
                    else
                        dur = $urandom_range(1, 270);
                    repeat (dur) send_tick(lv);
                    // some episodes run straight into the next one
                    if ($urandom_range(3) != 0)
                        repeat ($urandom_range(1, 3)) send_tick(KEYS_RELEASED);
                end
            end
        end

        // drain and settle
        key_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
